// ===== rtl/core/lrb_pkg.sv =====
// Shared types and constants for the link reconnect backoff controller.
// No dependencies; every module of the block imports this package.
package lrb_pkg;

    localparam int TIMER_BITS_DEF   = 16;
    localparam int ATTEMPT_BITS_DEF = 5;

    localparam int TICK_W    = 16;
    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int REQ_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [TICK_W-1:0] INITIAL_RETRY_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] MAX_RETRY_RESET     = 16'd30000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RETRY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRY     = 1'b1;

    typedef enum logic [1:0] {
        LS_DISC       = 2'd0,
        LS_CONNECTING = 2'd1,
        LS_CONNECTED  = 2'd2,
        LS_ERROR      = 2'd3
    } link_state_t;

    typedef enum logic [REQ_W-1:0] {
        EV_CONNECT    = 3'd0,
        EV_DISCONNECT = 3'd1,
        EV_LINK_UP    = 3'd2,
        EV_LINK_DOWN  = 3'd3,
        EV_LINK_ERROR = 3'd4,
        EV_TICK       = 3'd5
    } event_code_t;

    // One accepted event as held in the input stage
    typedef struct packed {
        logic              valid;
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] target_addr;
        logic [PORT_W-1:0] target_port;
    } event_t;

    // One result item, ordered from the top bit down
    typedef struct packed {
        logic [TICK_W-1:0] retry_interval;
        logic              retry_armed;
        logic              error_report;
        logic [PORT_W-1:0] peer_port;
        logic [ADDR_W-1:0] peer_addr;
        logic              disconnect_cmd;
        logic              connect_cmd;
        logic              state_changed;
        link_state_t       link_state;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int S_DATA_W = ((ADDR_W + PORT_W + 7) / 8) * 8;

endpackage

// ===== rtl/core/lrb_in_stage.sv =====
// Input register of the link reconnect backoff controller.
// Depends on lrb_pkg; holds one event until the control stage advances.
module lrb_in_stage
    import lrb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [REQ_W-1:0]    s_tuser,
    input  logic                advance,
    output event_t              evt
);

    event_t evt_reg;
    event_t evt_next;

    // Take a new transfer when the stage is empty or drains this cycle
    assign s_tready = !evt_reg.valid || advance;
    assign evt      = evt_reg;

    always_comb begin
        evt_next = evt_reg;
        if (s_tready) begin
            evt_next.valid       = s_tvalid;
            evt_next.req_type    = s_tuser;
            evt_next.target_addr = s_tdata[ADDR_W-1:0];
            evt_next.target_port = s_tdata[ADDR_W+PORT_W-1:ADDR_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evt_reg.valid <= 1'b0;
        end else begin
            evt_reg.valid <= evt_next.valid;
        end
        evt_reg.req_type    <= evt_next.req_type;
        evt_reg.target_addr <= evt_next.target_addr;
        evt_reg.target_port <= evt_next.target_port;
    end

endmodule

// ===== rtl/core/lrb_backoff.sv =====
// Retry interval registers and the shifted, clamped backoff interval.
// Depends on lrb_pkg; feeds the interval to the control stage.
module lrb_backoff
    import lrb_pkg::*;
#(
    parameter int TIMER_BITS   = TIMER_BITS_DEF,
    parameter int ATTEMPT_BITS = ATTEMPT_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [TICK_W-1:0]       cfg_wr_data,
    input  logic [ATTEMPT_BITS-1:0] attempts,
    output logic [TICK_W-1:0]       interval
);

    // Largest count the timer can hold, seen in 16 bits
    localparam logic [TICK_W-1:0] TIMER_CAP = (TIMER_BITS >= TICK_W) ? {TICK_W{1'b1}} :
        TICK_W'((64'd1 << TIMER_BITS) - 64'd1);

    logic [TICK_W-1:0]   initial_reg;
    logic [TICK_W-1:0]   max_reg;
    logic [7:0]          attempts_ext;
    logic                too_far;
    logic [2*TICK_W-1:0] shifted;
    logic [TICK_W-1:0]   clamped;

    // Hold the configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_reg <= INITIAL_RETRY_RESET;
            max_reg     <= MAX_RETRY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_INITIAL_RETRY: initial_reg <= cfg_wr_data;
                CFG_MAX_RETRY:     max_reg     <= cfg_wr_data;
                default:           ;
            endcase
        end
    end

    // A shift of 16 or more moves any nonzero start past every 16-bit ceiling
    always_comb begin
        attempts_ext = 8'(attempts);
        too_far      = (attempts_ext >= 8'd16) && (initial_reg != '0);
        shifted      = (2*TICK_W)'(initial_reg) << attempts_ext[3:0];
        if (too_far || (shifted > (2*TICK_W)'(max_reg))) begin
            clamped = max_reg;
        end else begin
            clamped = shifted[TICK_W-1:0];
        end
        interval = (clamped > TIMER_CAP) ? TIMER_CAP : clamped;
    end

endmodule

// ===== rtl/core/lrb_ctrl.sv =====
// Link state machine, retry timer and result register.
// Depends on lrb_pkg; takes events from lrb_in_stage and the interval from lrb_backoff.
module lrb_ctrl
    import lrb_pkg::*;
#(
    parameter int TIMER_BITS   = TIMER_BITS_DEF,
    parameter int ATTEMPT_BITS = ATTEMPT_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  event_t                  evt,
    input  logic [TICK_W-1:0]       interval,
    output logic [ATTEMPT_BITS-1:0] attempts,
    output logic                    advance,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output result_t                 result
);

    link_state_t             state_reg,    state_next;
    logic                    user_disc_reg, user_disc_next;
    logic [ATTEMPT_BITS-1:0] attempts_reg, attempts_next;
    logic                    timer_run_reg, timer_run_next;
    logic [TIMER_BITS-1:0]   remain_reg,   remain_next;
    logic [ADDR_W-1:0]       saved_addr_reg, saved_addr_next;
    logic [PORT_W-1:0]       saved_port_reg, saved_port_next;
    logic                    m_valid_reg,  m_valid_next;
    result_t                 result_reg,   res;
    logic                    step;
    logic                    arm;

    // Output register frees up when empty or when the sink takes it
    assign advance  = !m_valid_reg || m_tready;
    assign step     = evt.valid && advance;
    assign attempts = attempts_reg;
    assign m_tvalid = m_valid_reg;
    assign result   = result_reg;

    // Next state and result for the event in the input stage
    always_comb begin
        state_next      = state_reg;
        user_disc_next  = user_disc_reg;
        attempts_next   = attempts_reg;
        timer_run_next  = timer_run_reg;
        remain_next     = remain_reg;
        saved_addr_next = saved_addr_reg;
        saved_port_next = saved_port_reg;
        arm             = 1'b0;
        res             = '0;

        unique case (evt.req_type)
            EV_CONNECT: begin
                if (state_reg != LS_CONNECTED) begin
                    saved_addr_next = evt.target_addr;
                    saved_port_next = evt.target_port;
                    user_disc_next  = 1'b0;
                    attempts_next   = '0;
                    timer_run_next  = 1'b0;
                    state_next      = LS_CONNECTING;
                    res.connect_cmd = 1'b1;
                    res.peer_addr   = evt.target_addr;
                    res.peer_port   = evt.target_port;
                end
            end
            EV_DISCONNECT: begin
                user_disc_next     = 1'b1;
                timer_run_next     = 1'b0;
                res.disconnect_cmd = 1'b1;
                state_next         = LS_DISC;
            end
            EV_LINK_UP: begin
                user_disc_next = 1'b0;
                attempts_next  = '0;
                timer_run_next = 1'b0;
                state_next     = LS_CONNECTED;
            end
            EV_LINK_DOWN: begin
                if (user_disc_reg) begin
                    user_disc_next = 1'b0;
                    state_next     = LS_DISC;
                end else begin
                    state_next = LS_ERROR;
                    arm        = !timer_run_reg;
                end
            end
            EV_LINK_ERROR: begin
                res.error_report = 1'b1;
                state_next       = LS_ERROR;
                arm              = !user_disc_reg && !timer_run_reg;
            end
            EV_TICK: begin
                if (timer_run_reg) begin
                    if (remain_reg > TIMER_BITS'(1)) begin
                        remain_next = remain_reg - TIMER_BITS'(1);
                    end else begin
                        remain_next     = '0;
                        timer_run_next  = 1'b0;
                        state_next      = LS_CONNECTING;
                        res.connect_cmd = 1'b1;
                        res.peer_addr   = saved_addr_reg;
                        res.peer_port   = saved_port_reg;
                    end
                end
            end
            default: ;
        endcase

        // Arm the one-shot retry timer and count the attempt
        if (arm) begin
            if (attempts_reg != {ATTEMPT_BITS{1'b1}}) begin
                attempts_next = attempts_reg + ATTEMPT_BITS'(1);
            end
            timer_run_next     = 1'b1;
            remain_next        = TIMER_BITS'(interval);
            res.retry_armed    = 1'b1;
            res.retry_interval = interval;
        end

        res.link_state    = state_next;
        res.state_changed = (state_next != state_reg);

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = evt.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= LS_DISC;
            user_disc_reg <= 1'b0;
            attempts_reg  <= '0;
            timer_run_reg <= 1'b0;
            remain_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (step) begin
                state_reg     <= state_next;
                user_disc_reg <= user_disc_next;
                attempts_reg  <= attempts_next;
                timer_run_reg <= timer_run_next;
                remain_reg    <= remain_next;
            end
        end
    end

    // Payload registers: saved peer and the result
    always_ff @(posedge aclk) begin
        if (step) begin
            saved_addr_reg <= saved_addr_next;
            saved_port_reg <= saved_port_next;
            result_reg     <= res;
        end
    end

    // The retry timer only runs while the link sits in error
    a_timer_in_error: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_run_reg |-> (state_reg == LS_ERROR))
        else $error("retry timer running outside error state");

    // A retry is armed only on entering or staying in error
    a_armed_in_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.retry_armed) |-> (result_reg.link_state == LS_ERROR))
        else $error("retry armed outside error state");

    // A connect command always leaves the link connecting
    a_connect_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.connect_cmd) |->
            (result_reg.link_state == LS_CONNECTING))
        else $error("connect issued without connecting state");

    // Arming a retry starts the timer on the next cycle
    a_arm_starts_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && arm) |=> timer_run_reg)
        else $error("armed retry did not start the timer");

endmodule

// ===== rtl/core/link_reconnect_backoff_fsm.sv =====
// Link reconnect controller with exponential retry backoff.
// Path from input transfer to result: input register, then result register.
// Throughput: one event per cycle while the result sink accepts; the next state and
// the clamped interval settle in one pass of logic between the two registers.
// Reset (aresetn low, synchronous): link disconnected, timer idle, attempts zero,
// retry intervals back to 1000 and 30000 ticks; the saved peer is not cleared.
module link_reconnect_backoff_fsm
    import lrb_pkg::*;
#(
    parameter int TIMER_BITS   = TIMER_BITS_DEF,
    parameter int ATTEMPT_BITS = ATTEMPT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [TICK_W-1:0]    cfg_wr_data,
    // Event stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,  // target_addr[31:0], target_port[47:32]
    input  logic [REQ_W-1:0]     s_tuser,  // req_type[2:0]
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // link_state[1:0], state_changed[2], connect_cmd[3], disconnect_cmd[4],
    // peer_addr[36:5], peer_port[52:37], error_report[53], retry_armed[54],
    // retry_interval[70:55], zero pad[71]
    output logic [M_DATA_W-1:0]  m_tdata
);

    event_t                  evt;
    result_t                 result;
    logic                    advance;
    logic [ATTEMPT_BITS-1:0] attempts;
    logic [TICK_W-1:0]       interval;

    lrb_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .evt      (evt)
    );

    lrb_backoff #(
        .TIMER_BITS   (TIMER_BITS),
        .ATTEMPT_BITS (ATTEMPT_BITS)
    ) u_backoff (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .attempts    (attempts),
        .interval    (interval)
    );

    lrb_ctrl #(
        .TIMER_BITS   (TIMER_BITS),
        .ATTEMPT_BITS (ATTEMPT_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .evt      (evt),
        .interval (interval),
        .attempts (attempts),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    // Pack the result with zero fill to whole bytes
    assign m_tdata = M_DATA_W'(result);

endmodule
